/* rtl/core/sed_pkg.sv */
package sed_pkg;

  // configuration port
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam int HW_BITS    = 5;

  localparam logic [PADDR_BITS-1:0] ADDR_HALF_WINDOW  = 3'h0;
  localparam logic [HW_BITS-1:0]    HALF_WINDOW_RESET = 5'd2;

  // window entries folded per group in the first reduction stage
  localparam int GROUP_SIZE = 8;

endpackage

/* rtl/core/sed_in_if.sv */
interface sed_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/core/sed_out_if.sv */
interface sed_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] erosion;
  logic signed [SAMPLE_BITS-1:0] dilation;
  logic signed [SAMPLE_BITS-1:0] average;
  logic        [SAMPLE_BITS-1:0] difference;
  logic                          last_out;

  modport source (output valid, output erosion, output dilation, output average,
                  output difference, output last_out, input ready);
  modport sink   (input valid, input erosion, input dilation, input average,
                  input difference, input last_out, output ready);
endinterface

/* rtl/core/sed_front.sv */
module sed_front
  import sed_pkg::*;
#(
  parameter int MAX_HALF_WINDOW = 31,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [HW_BITS-1:0]  half_window,
  sed_in_if.sink              in_ch,
  output logic                q_push,
  output logic [2*SAMPLE_BITS+$clog2(MAX_HALF_WINDOW+2):0] q_data,
  input  logic                q_full
);

  localparam int DEPTH  = 2 * MAX_HALF_WINDOW;
  localparam int H_W    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int SEEN_W = H_W + 1;
  localparam int CNT_W  = $clog2(MAX_HALF_WINDOW + 2);
  localparam int NG     = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic signed [SAMPLE_BITS-1:0] VAL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] VAL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_PUSH   = 2'd2;

  logic [1:0]                    state;
  logic signed [SAMPLE_BITS-1:0] store [DEPTH];
  logic [SEEN_W-1:0]             seen;
  logic [SEEN_W-1:0]             win_len;
  logic [CNT_W-1:0]              item_count;
  logic                          item_last;
  logic signed [SAMPLE_BITS-1:0] grp_lo [NG];
  logic signed [SAMPLE_BITS-1:0] grp_hi [NG];

  logic [H_W-1:0]                h_eff;
  logic [SEEN_W-1:0]             two_h;
  logic [SEEN_W-1:0]             seen_inc;
  logic [SEEN_W-1:0]             win_len_next;
  logic                          past_half;
  logic [CNT_W-1:0]              cnt_tail;
  logic [CNT_W-1:0]              item_count_next;
  logic signed [SAMPLE_BITS-1:0] grp_lo_next [NG];
  logic signed [SAMPLE_BITS-1:0] grp_hi_next [NG];
  logic signed [SAMPLE_BITS-1:0] win_lo;
  logic signed [SAMPLE_BITS-1:0] win_hi;
  logic                          accept;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (half_window == '0) begin
      h_eff = H_W'(1);
    end else if (int'(half_window) > MAX_HALF_WINDOW) begin
      h_eff = H_W'(MAX_HALF_WINDOW);
    end else begin
      h_eff = H_W'(half_window);
    end
  end

  assign two_h        = {h_eff, 1'b0};
  assign seen_inc     = (seen < SEEN_W'(DEPTH)) ? seen + 1'b1 : seen;
  assign win_len_next = (seen_inc < two_h) ? seen_inc : two_h;
  assign past_half    = (seen >= {1'b0, h_eff});

  // one result once half a window of samples has been seen, plus the flush of the tail on last
  always_comb begin
    if (in_ch.last) begin
      cnt_tail = past_half ? CNT_W'(h_eff) : CNT_W'(seen) + 1'b1;
    end else begin
      cnt_tail = '0;
    end
    item_count_next = cnt_tail + (past_half ? CNT_W'(1) : CNT_W'(0));
  end

  // first stage: fold each group of stored samples, newest first
  always_comb begin
    int idx;
    for (int g = 0; g < NG; g++) begin
      grp_lo_next[g] = VAL_MAX;
      grp_hi_next[g] = VAL_MIN;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        idx = g * GROUP_SIZE + k;
        if (idx < DEPTH && idx < int'(win_len)) begin
          if (store[idx] < grp_lo_next[g]) grp_lo_next[g] = store[idx];
          if (store[idx] > grp_hi_next[g]) grp_hi_next[g] = store[idx];
        end
      end
    end
  end

  // second stage: fold the group results
  always_comb begin
    win_lo = VAL_MAX;
    win_hi = VAL_MIN;
    for (int g = 0; g < NG; g++) begin
      if (grp_lo[g] < win_lo) win_lo = grp_lo[g];
      if (grp_hi[g] > win_hi) win_hi = grp_hi[g];
    end
  end

  assign q_push = (state == ST_PUSH) && !q_full;
  assign q_data = {item_last, item_count, win_hi, win_lo};

  always_ff @(posedge clk) begin
    if (accept) begin
      store[0] <= in_ch.sample;
      for (int k = 1; k < DEPTH; k++) begin
        store[k] <= store[k-1];
      end
      win_len    <= win_len_next;
      item_count <= item_count_next;
      item_last  <= in_ch.last;
    end
    if (state == ST_REDUCE) begin
      for (int g = 0; g < NG; g++) begin
        grp_lo[g] <= grp_lo_next[g];
        grp_hi[g] <= grp_hi_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seen  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            seen  <= in_ch.last ? '0 : seen_inc;
            state <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!q_full) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_reduce_then_push: assert property (@(posedge clk) disable iff (rst)
    state == ST_REDUCE |=> state == ST_PUSH)
    else $error("front: reduce stage not followed by push");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.last) |=> seen == '0)
    else $error("front: sample count not cleared after last");

  a_window_sane: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (win_len != '0 && win_hi >= win_lo))
    else $error("front: empty or inverted window pushed");
`endif

endmodule

/* rtl/core/sed_queue.sv */
module sed_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue: write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue: read while empty");
`endif

endmodule

/* rtl/core/sed_back.sv */
module sed_back #(
  parameter int MAX_HALF_WINDOW = 31,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic [2*SAMPLE_BITS+$clog2(MAX_HALF_WINDOW+2):0] q_data,
  input  logic  q_empty,
  output logic  q_pop,
  sed_out_if.source out_ch
);

  localparam int W     = SAMPLE_BITS;
  localparam int CNT_W = $clog2(MAX_HALF_WINDOW + 2);

  logic signed [W-1:0] cur_lo;
  logic signed [W-1:0] cur_hi;
  logic                cur_last;
  logic [CNT_W-1:0]    remaining;

  logic                out_valid;
  logic signed [W-1:0] out_erosion;
  logic signed [W-1:0] out_dilation;
  logic signed [W-1:0] out_average;
  logic [W-1:0]        out_difference;
  logic                out_last;

  logic                load_out;
  logic                give;
  logic signed [W:0]   sum;
  logic signed [W:0]   sum_adj;

  assign load_out = !out_valid || out_ch.ready;
  assign give     = load_out && (remaining != '0);
  assign q_pop    = !q_empty && (remaining == '0);

  // bias negatives by one so the shift truncates toward zero
  assign sum     = {cur_lo[W-1], cur_lo} + {cur_hi[W-1], cur_hi};
  assign sum_adj = sum + {{W{1'b0}}, sum[W]};

  assign out_ch.valid      = out_valid;
  assign out_ch.erosion    = out_erosion;
  assign out_ch.dilation   = out_dilation;
  assign out_ch.average    = out_average;
  assign out_ch.difference = out_difference;
  assign out_ch.last_out   = out_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_lo   <= q_data[W-1:0];
      cur_hi   <= q_data[2*W-1:W];
      cur_last <= q_data[2*W+CNT_W];
    end
    if (give) begin
      out_erosion    <= cur_lo;
      out_dilation   <= cur_hi;
      out_average    <= sum_adj[W:1];
      out_difference <= cur_hi - cur_lo;
      out_last       <= cur_last && (remaining == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        remaining <= q_data[2*W+CNT_W-1:2*W];
      end else if (give) begin
        remaining <= remaining - 1'b1;
      end
      if (load_out) out_valid <= give;
    end
  end

endmodule

/* rtl/core/sliding_erosion_dilation.sv */
// Channel   Dir  Payload                                            Handshake
// in_ch     in   sample, last                                       valid/ready
// out_ch    out  erosion, dilation, average, difference, last_out   valid/ready
// apb       in   half_window at byte address 0                      psel/penable, pready=1
//
// Front end takes a new sample only after the last one's steps: accept/shift, group min/max, final
// min/max and queue write. Back end sends one result per cycle from its output register while
// out_ch is ready; each queued request is popped before its results are sent.
// Reset (rst, synchronous) clears control and sample count; the sample store is not cleared.
// A 2-deep queue decouples the two ends; a stalled output holds the back end at once
// and the front end only once the queue is full.
module sliding_erosion_dilation
  import sed_pkg::*;
#(
  parameter int MAX_HALF_WINDOW = 31,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  sed_in_if.sink                in_ch,
  sed_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  localparam int ENT_W = 2 * SAMPLE_BITS + $clog2(MAX_HALF_WINDOW + 2) + 1;

  logic [HW_BITS-1:0] half_window;
  logic               cfg_wr;
  logic               hw_sel;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic [ENT_W-1:0]   q_wr_data;
  logic [ENT_W-1:0]   q_rd_data;

  // registers are decoded by word, byte offset ignored
  assign hw_sel = (paddr[PADDR_BITS-1:2] == ADDR_HALF_WINDOW[PADDR_BITS-1:2]);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = hw_sel ? PDATA_BITS'(half_window) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= HALF_WINDOW_RESET;
    end else if (cfg_wr && hw_sel) begin
      half_window <= pwdata[HW_BITS-1:0];
    end
  end

  sed_front #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .half_window (half_window),
    .in_ch       (in_ch),
    .q_push      (q_push),
    .q_data      (q_wr_data),
    .q_full      (q_full)
  );

  sed_queue #(
    .WIDTH (ENT_W),
    .DEPTH (2)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  sed_back #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rd_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench
  import sed_pkg::*;
();

  localparam int SBITS        = 16;
  localparam int MAX_HW       = 31;
  localparam int DEPTH        = 2 * MAX_HW;
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE       = 16;       // margin for the front end's steps per sample, plus queue
  localparam int LIMIT        = 500000;

  typedef struct packed {
    logic signed [SBITS-1:0] erosion;
    logic signed [SBITS-1:0] dilation;
    logic signed [SBITS-1:0] average;
    logic        [SBITS-1:0] difference;
    logic                    last_out;
  } extent_t;

  typedef struct {
    bit                      cfg_en;
    logic [PDATA_BITS-1:0]   cfg_val;
    logic signed [SBITS-1:0] smp;
    bit                      lst;
    int                      ntyped;
    extent_t                 typed;
  } step_row_t;

  typedef enum int {MIX_FULL, MIX_NARROW, MIX_EDGE} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  psel, penable, pwrite, pready;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata, prdata;

  sed_in_if  #(.SAMPLE_BITS(SBITS)) in_ch ();
  sed_out_if #(.SAMPLE_BITS(SBITS)) out_ch ();

  sliding_erosion_dilation dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // shadow state of the filter
  logic signed [SBITS-1:0] win_hist [DEPTH];
  int                      fill = 0;
  logic [HW_BITS-1:0]      half_reg = HALF_WINDOW_RESET;
  extent_t                 pending [$];

  // directed rows may force their own expectation
  int      typed_count = 0;
  extent_t typed_val;

  bit  no_gaps = 1'b0;
  int  errors = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_waves = 0;
  int  n_settings = 0;
  int  cycles = 0;

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Queue the results that one sample releases; returns how many.
  function automatic int predict_window(logic signed [SBITS-1:0] x, logic lst);
    int h, prior, n, cnt, s;
    logic signed [SBITS-1:0] lo, hi;
    extent_t e;
    h = (half_reg == '0) ? 1 : int'(half_reg);
    if (h > MAX_HW) h = MAX_HW;
    prior = fill;
    for (int k = DEPTH - 1; k > 0; k--) win_hist[k] = win_hist[k-1];
    win_hist[0] = x;
    if (fill < DEPTH) fill++;
    n = (fill < 2 * h) ? fill : 2 * h;
    lo = win_hist[n-1];
    hi = win_hist[n-1];
    for (int k = n - 2; k >= 0; k--) begin
      if (win_hist[k] < lo) lo = win_hist[k];
      if (win_hist[k] > hi) hi = win_hist[k];
    end
    cnt = (prior >= h) ? 1 : 0;
    if (lst) cnt += (prior >= h) ? h : prior + 1;
    s = int'(lo) + int'(hi);
    e.erosion    = lo;
    e.dilation   = hi;
    e.average    = SBITS'(s / 2);
    e.difference = SBITS'(int'(hi) - int'(lo));
    for (int j = 0; j < cnt; j++) begin
      e.last_out = lst && (j == cnt - 1);
      pending.insert(pending.size(), e);
    end
    if (lst) fill = 0;
    return cnt;
  endfunction

  always @(posedge clk) begin
    extent_t entry;
    int made;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        made = predict_window(in_ch.sample, in_ch.last);
        if (typed_count > 0) begin
          repeat (made) void'(pending.pop_back());
          for (int j = 0; j < typed_count; j++) begin
            entry = typed_val;
            entry.last_out = in_ch.last && (j == typed_count - 1);
            pending.insert(pending.size(), entry);
          end
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending.size() == 0) begin
          report_mismatch($sformatf("unexpected result erosion %0d dilation %0d",
                                    out_ch.erosion, out_ch.dilation));
        end else begin
          entry = pending.pop_front();
          if (out_ch.erosion !== entry.erosion)
            report_mismatch($sformatf("result %0d erosion %0d, want %0d",
                                      n_checked, out_ch.erosion, entry.erosion));
          if (out_ch.dilation !== entry.dilation)
            report_mismatch($sformatf("result %0d dilation %0d, want %0d",
                                      n_checked, out_ch.dilation, entry.dilation));
          if (out_ch.average !== entry.average)
            report_mismatch($sformatf("result %0d average %0d, want %0d",
                                      n_checked, out_ch.average, entry.average));
          if (out_ch.difference !== entry.difference)
            report_mismatch($sformatf("result %0d difference %0d, want %0d",
                                      n_checked, out_ch.difference, entry.difference));
          if (out_ch.last_out !== entry.last_out)
            report_mismatch($sformatf("result %0d last_out %0b, want %0b",
                                      n_checked, out_ch.last_out, entry.last_out));
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("testbench failed");
      $finish;
    end
  end

  // output side back-pressure, drawn per result
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(logic signed [SBITS-1:0] x, logic lst);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= x;
    in_ch.last   <= lst;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apb_access(bit wr, logic [PDATA_BITS-1:0] wdata,
                            output logic [PDATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_HALF_WINDOW;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) half_reg = wdata[HW_BITS-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_half(logic [PDATA_BITS-1:0] val);
    logic [PDATA_BITS-1:0] rd;
    apb_access(1'b1, val, rd);
    apb_access(1'b0, '0, rd);
    if (rd[HW_BITS-1:0] !== val[HW_BITS-1:0])
      report_mismatch($sformatf("half_window reads %0d after writing %0d",
                                rd[HW_BITS-1:0], val[HW_BITS-1:0]));
    n_settings++;
  endtask

  function automatic logic signed [SBITS-1:0] draw_sample(mix_t mix);
    logic signed [SBITS-1:0] corner [4];
    corner = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1};
    case (mix)
      MIX_NARROW: return SBITS'($urandom_range(0, 6)) - 16'sd3;
      MIX_EDGE:   return corner[$urandom_range(0, 3)];
      default:    return SBITS'($urandom);
    endcase
  endfunction

  step_row_t plan [$];

  function automatic void add_row(bit cfg_en, logic [PDATA_BITS-1:0] cfg_val, int smp,
                                  bit lst, int ntyped, int ero, int dil, int avg, int diff);
    step_row_t r;
    r.cfg_en             = cfg_en;
    r.cfg_val            = cfg_val;
    r.smp                = SBITS'(smp);
    r.lst                = lst;
    r.ntyped             = ntyped;
    r.typed.erosion      = SBITS'(ero);
    r.typed.dilation     = SBITS'(dil);
    r.typed.average      = SBITS'(avg);
    r.typed.difference   = SBITS'(diff);
    r.typed.last_out     = 1'b0;
    plan.insert(plan.size(), r);
  endfunction

  initial begin
    logic [PDATA_BITS-1:0] rd;
    int hw, h_eff, pick, nwave, len, n_random;
    bit open_end;
    mix_t mix;
    logic [PDATA_BITS-1:0] cfg;

    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    for (int k = 0; k < DEPTH; k++) win_hist[k] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    apb_access(1'b0, '0, rd);
    if (rd[HW_BITS-1:0] !== HALF_WINDOW_RESET)
      report_mismatch($sformatf("half_window after reset is %0d", rd[HW_BITS-1:0]));

    //      cfg  value         sample  last  n  erosion dilation average diff
    add_row(0,   0,            -32768, 1,    1, -32768, -32768,  -32768, 0);
    add_row(0,   0,             32767, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,            -32768, 1,    2, -32768, 32767,   0,      65535);
    add_row(0,   0,                -1, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                -2, 1,    2, -2,     -1,      -1,     1);
    add_row(0,   0,                 5, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                 5, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                -3, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                 7, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                -3, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                 7, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                 0, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                 1, 1,    0, 0,      0,       0,      0);
    add_row(1,   0,               100, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,              -100, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                 3, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                 3, 0,    0, 0,      0,       0,      0);
    add_row(0,   0,                42, 1,    0, 0,      0,       0,      0);
    add_row(1,   31,                1, 0,    0, 0,      0,       0,      0);
    add_row(1,   32'hffffffe3,      2, 1,    0, 0,      0,       0,      0);
    add_row(0,   0,             32767, 1,    1, 32767,  32767,   32767,  0);

    foreach (plan[i]) begin
      if (plan[i].cfg_en) begin
        settle();
        write_half(plan[i].cfg_val);
      end
      typed_count = plan[i].ntyped;
      typed_val   = plan[i].typed;
      send_sample(plan[i].smp, plan[i].lst);
      typed_count = 0;
      if (plan[i].lst) n_waves++;
    end

    // random phases; a phase may stop mid-waveform so the next setting lands inside it
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 9);
      if (pick == 0) hw = 0;
      else if (pick == 1) hw = MAX_HW;
      else if (pick < 7) hw = $urandom_range(1, 4);
      else hw = $urandom_range(0, MAX_HW);
      cfg = $urandom;
      cfg[HW_BITS-1:0] = HW_BITS'(hw);
      write_half(cfg);
      h_eff = (hw == 0) ? 1 : hw;
      no_gaps = ($urandom_range(0, 3) == 0);
      nwave = $urandom_range(1, 4);
      for (int w = 0; w < nwave && n_random < RANDOM_ITEMS; w++) begin
        case ($urandom_range(0, 7))
          0:       len = $urandom_range(1, h_eff);
          1:       len = h_eff;
          2:       len = h_eff + 1;
          3:       len = $urandom_range(DEPTH - 2, DEPTH + 8);
          default: len = $urandom_range(1, 2 * h_eff + 3);
        endcase
        if (len > RANDOM_ITEMS - n_random) len = RANDOM_ITEMS - n_random;
        mix = mix_t'($urandom_range(0, 2));
        open_end = (w == nwave - 1) && ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++) begin
          send_sample(draw_sample(mix), (k == len - 1) && !open_end);
          n_random++;
        end
        if (!open_end) n_waves++;
      end
    end
    no_gaps = 1'b0;
    settle();

    $display("sent %0d samples in %0d closed waveforms over %0d half-window settings",
             n_sent, n_waves, n_settings);
    $display("checked %0d window results, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
